[rtl/cte_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cte_pkg;

	localparam int TIME_W     = 32;
	localparam int PNUM_W     = 6;
	localparam int PINCFG_W   = 4;
	localparam int FIRST_W    = 5;
	localparam int SPC_W      = 20;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [PINCFG_W-1:0] RST_PINS  = 4'd2;
	localparam logic [FIRST_W-1:0]  RST_FIRST = 5'd22;
	localparam logic [SPC_W-1:0]    RST_SPC   = 20'd9600;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PINS  = 2'd0,
		REG_FIRST = 2'd1,
		REG_SPC   = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [PINCFG_W-1:0] pins_in_use;
		logic [FIRST_W-1:0]  first_pin_number;
		logic [SPC_W-1:0]    samples_per_capture;
	} cfg_t;

	typedef struct packed {
		logic [PNUM_W-1:0] pin_number;
		logic              new_level;
		logic [TIME_W-1:0] sample_time;
		logic              last_of_word;
	} event_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FLUSH
	} back_state_t;

endpackage

`default_nettype wire

[rtl/cte_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface cte_cap_if #(parameter int WORD_BITS = 32);
	logic                 valid;
	logic                 ready;
	logic [WORD_BITS-1:0] capture_word;

	modport source(output valid, output capture_word, input ready);
	modport sink(input valid, input capture_word, output ready);
endinterface

interface cte_evt_if;
	logic                        valid;
	logic                        ready;
	logic [cte_pkg::PNUM_W-1:0]  pin_number;
	logic                        new_level;
	logic [cte_pkg::TIME_W-1:0]  sample_time;
	logic                        last_of_word;

	modport source(output valid, output pin_number, output new_level,
		output sample_time, output last_of_word, input ready);
	modport sink(input valid, input pin_number, input new_level,
		input sample_time, input last_of_word, output ready);
endinterface

`default_nettype wire

[rtl/capture_transition_extractor.sv]
`timescale 1ns / 1ps
`default_nettype none

// Turns packed capture words into pin transition items (pin, new level, sample time,
// last-of-word mark). The front side classifies a word in the cycle it is accepted
// (layout from the pin count, samples left in the capture, start time) and places it
// in a two-entry queue; it takes a word every cycle while the queue has room. The back
// side walks the queued word one sample per cycle unless a sample holds further changes
// or a pending item cannot leave; each further change in a sample takes a step of its
// own, and each word also passes a load step and a flush step. The flush step exists
// because an item is held back so that the final item of a word can carry its mark.
// Results leave through an output register, so the back side keeps working while a
// result waits, until it has a further item to pass on. Configuration writes are taken
// at any time and must only happen while the block is idle.
module capture_transition_extractor #(
	parameter int WORD_BITS = 32,
	parameter int MAX_PINS  = 8
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [cte_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [cte_pkg::CFG_DATA_W-1:0]   cfg_data,
	cte_cap_if.sink                               cap,
	cte_evt_if.source                             evt
);

	localparam int PMAX    = (MAX_PINS < WORD_BITS) ? MAX_PINS : WORD_BITS;
	localparam int PMAXC   = (PMAX < 15) ? PMAX : 15;
	localparam int ENTRY_W = WORD_BITS + $clog2(PMAXC + 1) + $clog2(WORD_BITS + 1)
		+ cte_pkg::TIME_W;

	cte_pkg::cfg_t      cfg_q;
	logic               q_push;
	logic               q_full;
	logic               q_pop;
	logic               q_empty;
	logic [ENTRY_W-1:0] q_wdata;
	logic [ENTRY_W-1:0] q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pins_in_use         <= cte_pkg::RST_PINS;
			cfg_q.first_pin_number    <= cte_pkg::RST_FIRST;
			cfg_q.samples_per_capture <= cte_pkg::RST_SPC;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cte_pkg::REG_PINS: begin
					cfg_q.pins_in_use <= cfg_data[cte_pkg::PINCFG_W-1:0];
				end
				cte_pkg::REG_FIRST: begin
					cfg_q.first_pin_number <= cfg_data[cte_pkg::FIRST_W-1:0];
				end
				cte_pkg::REG_SPC: begin
					cfg_q.samples_per_capture <= cfg_data[cte_pkg::SPC_W-1:0];
				end
				default: begin
					// drop writes to unknown registers
				end
			endcase
		end
	end

	cte_front #(
		.WORD_BITS(WORD_BITS),
		.MAX_PINS (MAX_PINS)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_q),
		.cap   (cap),
		.q_full(q_full),
		.q_push(q_push),
		.q_data(q_wdata)
	);

	cte_queue #(
		.W(ENTRY_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_wdata),
		.full     (q_full),
		.pop      (q_pop),
		.pop_data (q_rdata),
		.empty    (q_empty)
	);

	cte_back #(
		.WORD_BITS(WORD_BITS),
		.MAX_PINS (MAX_PINS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.q_empty(q_empty),
		.q_pop  (q_pop),
		.q_data (q_rdata),
		.evt    (evt)
	);

endmodule

`default_nettype wire

[rtl/cte_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module cte_queue #(
	parameter int W = 1
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] push_data,
	output logic              full,
	input  wire logic         pop,
	output logic [W-1:0]      pop_data,
	output logic              empty
);

	localparam int DEPTH = cte_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

[rtl/cte_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module cte_front #(
	parameter int WORD_BITS = 32,
	parameter int MAX_PINS  = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cte_pkg::cfg_t cfg,
	cte_cap_if.sink            cap,
	input  wire logic          q_full,
	output logic               q_push,
	output logic [WORD_BITS + $clog2(((((MAX_PINS < WORD_BITS) ? MAX_PINS : WORD_BITS)
		< 15) ? ((MAX_PINS < WORD_BITS) ? MAX_PINS : WORD_BITS) : 15) + 1)
		+ $clog2(WORD_BITS + 1) + cte_pkg::TIME_W - 1:0] q_data
);

	localparam int PMAX  = (MAX_PINS < WORD_BITS) ? MAX_PINS : WORD_BITS;
	localparam int PMAXC = (PMAX < 15) ? PMAX : 15;
	localparam int PIN_W = $clog2(PMAXC + 1);
	localparam int CNT_W = $clog2(WORD_BITS + 1);
	localparam int TI_W  = (PMAXC > 1) ? $clog2(PMAXC) : 1;
	localparam int SPC_W = cte_pkg::SPC_W;

	typedef struct packed {
		logic [WORD_BITS-1:0]       word;
		logic [PIN_W-1:0]           pins;
		logic [CNT_W-1:0]           samples;
		logic [cte_pkg::TIME_W-1:0] start_time;
	} entry_t;

	logic [CNT_W-1:0] per_word_tab [PMAXC];
	logic [CNT_W-1:0] base_tab [PMAXC];

	for (genvar g = 0; g < PMAXC; g++) begin : g_tab
		localparam int PerWord = WORD_BITS / (g + 1);
		localparam int Base    = WORD_BITS - PerWord * (g + 1);
		assign per_word_tab[g] = CNT_W'(PerWord);
		assign base_tab[g]     = CNT_W'(Base);
	end

	logic [SPC_W-1:0]           sic_q;
	logic [cte_pkg::TIME_W-1:0] time_q;

	logic [PIN_W-1:0] pins;
	logic [TI_W-1:0]  tab_idx;
	logic [CNT_W-1:0] per_word;
	logic [CNT_W-1:0] base;
	logic [SPC_W-1:0] cap_len;
	logic [SPC_W-1:0] rem;
	logic             ends;
	logic [CNT_W-1:0] n;
	logic             accept;
	entry_t           entry;

	always_comb begin
		if (cfg.pins_in_use == '0) begin
			pins = PIN_W'(1);
		end else if (cfg.pins_in_use > cte_pkg::PINCFG_W'(PMAXC)) begin
			pins = PIN_W'(PMAXC);
		end else begin
			pins = PIN_W'(cfg.pins_in_use);
		end
	end

	assign tab_idx  = TI_W'(pins - PIN_W'(1));
	assign per_word = per_word_tab[tab_idx];
	assign base     = base_tab[tab_idx];

	// a capture already past a lowered length still takes one sample
	assign cap_len = (cfg.samples_per_capture == '0) ? SPC_W'(1) : cfg.samples_per_capture;
	assign rem     = (sic_q >= cap_len) ? SPC_W'(1) : cap_len - sic_q;
	assign ends    = (rem <= SPC_W'(per_word));
	assign n       = ends ? CNT_W'(rem) : per_word;

	assign cap.ready = !q_full;
	assign accept    = cap.valid && !q_full;
	assign q_push    = accept;

	always_comb begin
		entry.word       = cap.capture_word >> base;
		entry.pins       = pins;
		entry.samples    = n;
		entry.start_time = time_q;
	end

	assign q_data = entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sic_q  <= '0;
			time_q <= '0;
		end else if (accept) begin
			sic_q  <= ends ? '0 : sic_q + SPC_W'(n);
			time_q <= time_q + cte_pkg::TIME_W'(n);
		end
	end

endmodule

`default_nettype wire

[rtl/cte_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module cte_back #(
	parameter int WORD_BITS = 32,
	parameter int MAX_PINS  = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cte_pkg::cfg_t cfg,
	input  wire logic          q_empty,
	output logic               q_pop,
	input  wire logic [WORD_BITS + $clog2(((((MAX_PINS < WORD_BITS) ? MAX_PINS : WORD_BITS)
		< 15) ? ((MAX_PINS < WORD_BITS) ? MAX_PINS : WORD_BITS) : 15) + 1)
		+ $clog2(WORD_BITS + 1) + cte_pkg::TIME_W - 1:0] q_data,
	cte_evt_if.source          evt
);

	localparam int PMAX  = (MAX_PINS < WORD_BITS) ? MAX_PINS : WORD_BITS;
	localparam int LVL_N = (PMAX < 15) ? PMAX : 15;
	localparam int PIN_W = $clog2(LVL_N + 1);
	localparam int CNT_W = $clog2(WORD_BITS + 1);
	localparam int IDX_W = (LVL_N > 1) ? $clog2(LVL_N) : 1;
	localparam int PNUM_W = cte_pkg::PNUM_W;

	typedef struct packed {
		logic [WORD_BITS-1:0]       word;
		logic [PIN_W-1:0]           pins;
		logic [CNT_W-1:0]           samples;
		logic [cte_pkg::TIME_W-1:0] start_time;
	} entry_t;

	cte_pkg::back_state_t st_q, st_d;

	entry_t                     entry;
	logic [WORD_BITS-1:0]       sh_q;
	logic [PIN_W-1:0]           pins_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [cte_pkg::TIME_W-1:0] t_q;
	logic [LVL_N-1:0]           lvl_q;
	cte_pkg::event_t            hold_q;
	logic                       hold_v_q;
	cte_pkg::event_t            out_q;
	logic                       ov_q;

	logic [LVL_N-1:0] pmask;
	logic [LVL_N-1:0] smp;
	logic [LVL_N-1:0] diff;
	logic [LVL_N-1:0] low_oh;
	logic [IDX_W-1:0] low_idx;
	logic             has_ev;
	logic             advance;
	logic             last_smp;
	logic             can_push;
	logic             go;
	logic             load;
	logic             take_ev;
	logic             adv;
	logic             flush_push;
	logic             do_push;
	cte_pkg::event_t  new_ev;
	cte_pkg::event_t  push_ev;

	assign entry = q_data;

	always_comb begin
		for (int i = 0; i < LVL_N; i++) begin
			pmask[i] = (32'(i) < 32'(pins_q));
		end
	end

	assign smp    = sh_q[LVL_N-1:0];
	assign diff   = (smp ^ lvl_q) & pmask;
	assign low_oh = diff & (~diff + LVL_N'(1));

	always_comb begin
		low_idx = '0;
		for (int i = LVL_N - 1; i >= 0; i--) begin
			if (diff[i]) begin
				low_idx = IDX_W'(i);
			end
		end
	end

	assign has_ev   = |diff;
	// the sample is done once at most its lowest change is left
	assign advance  = ((diff & ~low_oh) == '0);
	assign last_smp = (cnt_q == CNT_W'(1));
	assign can_push = !ov_q || evt.ready;

	always_comb begin
		new_ev.pin_number   = PNUM_W'(cfg.first_pin_number) + PNUM_W'(low_idx);
		new_ev.new_level    = smp[low_idx];
		new_ev.sample_time  = t_q;
		new_ev.last_of_word = 1'b0;
	end

	always_comb begin
		st_d       = st_q;
		load       = 1'b0;
		go         = 1'b0;
		take_ev    = 1'b0;
		adv        = 1'b0;
		flush_push = 1'b0;
		unique case (st_q)
			cte_pkg::ST_IDLE: begin
				load = !q_empty;
				if (!q_empty) begin
					st_d = cte_pkg::ST_RUN;
				end
			end
			cte_pkg::ST_RUN: begin
				// hold while the pending item cannot leave
				go      = !(has_ev && hold_v_q) || can_push;
				take_ev = go && has_ev;
				adv     = go && advance;
				if (adv && last_smp) begin
					st_d = cte_pkg::ST_FLUSH;
				end
			end
			cte_pkg::ST_FLUSH: begin
				flush_push = hold_v_q && can_push;
				if (!hold_v_q || can_push) begin
					st_d = cte_pkg::ST_IDLE;
				end
			end
			default: begin
				st_d = cte_pkg::ST_IDLE;
			end
		endcase
	end

	assign q_pop   = load;
	assign do_push = (take_ev && hold_v_q) || flush_push;

	always_comb begin
		push_ev              = hold_q;
		push_ev.last_of_word = flush_push;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= cte_pkg::ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q    <= '0;
			hold_v_q <= 1'b0;
			ov_q     <= 1'b0;
		end else begin
			if (do_push) begin
				ov_q <= 1'b1;
			end else if (evt.ready) begin
				ov_q <= 1'b0;
			end
			if (take_ev) begin
				lvl_q    <= lvl_q ^ low_oh;
				hold_v_q <= 1'b1;
			end else if (flush_push) begin
				hold_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sh_q   <= entry.word;
			pins_q <= entry.pins;
			cnt_q  <= entry.samples;
			t_q    <= entry.start_time;
		end else if (adv) begin
			sh_q  <= sh_q >> pins_q;
			cnt_q <= cnt_q - CNT_W'(1);
			t_q   <= t_q + cte_pkg::TIME_W'(1);
		end
		if (take_ev) begin
			hold_q <= new_ev;
		end
		if (do_push) begin
			out_q <= push_ev;
		end
	end

	assign evt.valid        = ov_q;
	assign evt.pin_number   = out_q.pin_number;
	assign evt.new_level    = out_q.new_level;
	assign evt.sample_time  = out_q.sample_time;
	assign evt.last_of_word = out_q.last_of_word;

	a_run_has_samples: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == cte_pkg::ST_RUN) |-> (cnt_q != '0))
		else $error("sample count empty while running");

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == cte_pkg::ST_IDLE) |-> !hold_v_q)
		else $error("pending item left over after word");

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		flush_push |=> (!hold_v_q && ov_q && evt.last_of_word))
		else $error("final item of word not presented");

endmodule

`default_nettype wire

[dv/tb_capture_transition_extractor.sv]
`timescale 1ns / 1ps

module tb_capture_transition_extractor;

	localparam logic [cte_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int WORD_W        = 32;
	localparam int PIN_LIMIT     = 8;
	localparam int SETTLE_CYCLES = 150;
	localparam int MAX_PRINTS    = 200;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_WORDS   = 26;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_we;
	logic [cte_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [cte_pkg::CFG_DATA_W-1:0] cfg_data;

	cte_cap_if #(.WORD_BITS(WORD_W)) cap_bus ();
	cte_evt_if evt_bus ();

	capture_transition_extractor #(.WORD_BITS(WORD_W), .MAX_PINS(PIN_LIMIT)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cap(cap_bus),
		.evt(evt_bus)
	);

	// predictor copy of the registers and the capture state
	logic [cte_pkg::PINCFG_W-1:0] pins_reg;
	logic [cte_pkg::FIRST_W-1:0]  first_reg;
	logic [cte_pkg::SPC_W-1:0]    length_reg;
	logic [PIN_LIMIT-1:0]         pin_level;
	logic [cte_pkg::SPC_W-1:0]    capture_pos;
	logic [cte_pkg::TIME_W-1:0]   sample_clock;

	cte_pkg::event_t expected_events[$];
	cte_pkg::event_t want_ev;
	int              mismatch_count = 0;
	bit              calm = 1'b0;

	always #4 clk = ~clk;

	always @(negedge clk) begin
		evt_bus.ready <= calm || ($urandom_range(99) >= 15);
	end

	task automatic report_mismatch(input string what);
		if (mismatch_count < MAX_PRINTS)
			$display("%0t ns: mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		if (arst_n && evt_bus.valid && evt_bus.ready) begin
			if (expected_events.size() == 0) begin
				report_mismatch($sformatf("unexpected item pin %0d level %0d time %0d",
					evt_bus.pin_number, evt_bus.new_level, evt_bus.sample_time));
			end else begin
				want_ev = expected_events.pop_front();
				if (evt_bus.pin_number !== want_ev.pin_number)
					report_mismatch($sformatf("pin_number %0d, want %0d",
						evt_bus.pin_number, want_ev.pin_number));
				if (evt_bus.new_level !== want_ev.new_level)
					report_mismatch($sformatf("new_level %0d, want %0d (pin %0d)",
						evt_bus.new_level, want_ev.new_level, want_ev.pin_number));
				if (evt_bus.sample_time !== want_ev.sample_time)
					report_mismatch($sformatf("sample_time %0d, want %0d (pin %0d)",
						evt_bus.sample_time, want_ev.sample_time, want_ev.pin_number));
				if (evt_bus.last_of_word !== want_ev.last_of_word)
					report_mismatch($sformatf("last_of_word %0d, want %0d (time %0d)",
						evt_bus.last_of_word, want_ev.last_of_word, want_ev.sample_time));
			end
		end
	end

	function automatic int unsigned active_pins();
		if (pins_reg == '0)
			return 1;
		if (pins_reg > cte_pkg::PINCFG_W'(PIN_LIMIT))
			return PIN_LIMIT;
		return 32'(pins_reg);
	endfunction

	// walk the samples of one word and queue an item per pin level change
	function automatic void predict_transitions(input logic [WORD_W-1:0] w);
		int unsigned     npins, per_word, base, cap_len;
		logic            lv;
		cte_pkg::event_t ev;
		cte_pkg::event_t word_events[$];
		npins    = active_pins();
		per_word = WORD_W / npins;
		base     = WORD_W - per_word * npins;
		cap_len  = (length_reg == '0) ? 1 : 32'(length_reg);
		for (int unsigned s = 0; s < per_word; s++) begin
			for (int unsigned p = 0; p < npins; p++) begin
				lv = w[base + s * npins + p];
				if (lv != pin_level[p]) begin
					ev.pin_number   = cte_pkg::PNUM_W'(32'(first_reg) + p);
					ev.new_level    = lv;
					ev.sample_time  = sample_clock;
					ev.last_of_word = 1'b0;
					word_events.push_back(ev);
					pin_level[p] = lv;
				end
			end
			sample_clock++;
			capture_pos++;
			// the rest of the word lies past the end of the capture
			if (capture_pos >= cte_pkg::SPC_W'(cap_len)) begin
				capture_pos = '0;
				break;
			end
		end
		if (word_events.size() > 0) begin
			ev = word_events.pop_back();
			ev.last_of_word = 1'b1;
			word_events.push_back(ev);
		end
		foreach (word_events[i])
			expected_events.push_back(word_events[i]);
	endfunction

	// word whose samples repeat the current levels, with the given number of random bit flips
	function automatic logic [WORD_W-1:0] quiet_word(input int unsigned flips);
		int unsigned      npins, base;
		logic [WORD_W-1:0] w;
		npins = active_pins();
		base  = WORD_W - (WORD_W / npins) * npins;
		w     = $urandom;
		for (int unsigned b = base; b < WORD_W; b++)
			w[b] = pin_level[(b - base) % npins];
		for (int unsigned k = 0; k < flips; k++)
			w[$urandom_range(WORD_W - 1)] ^= 1'b1;
		return w;
	endfunction

	task automatic send_word(input logic [WORD_W-1:0] w);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 15) begin
			cap_bus.valid <= 1'b0;
			@(negedge clk);
		end
		cap_bus.valid        <= 1'b1;
		cap_bus.capture_word <= w;
		@(posedge clk);
		while (!cap_bus.ready)
			@(posedge clk);
		predict_transitions(w);
	endtask

	// drop valid, wait out every pending item, then let the back side go quiet
	task automatic settle();
		@(negedge clk);
		cap_bus.valid <= 1'b0;
		while (expected_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [cte_pkg::CFG_IDX_W-1:0] idx,
		input logic [cte_pkg::CFG_DATA_W-1:0] val);
		settle();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			cte_pkg::REG_PINS:  pins_reg   = val[cte_pkg::PINCFG_W-1:0];
			cte_pkg::REG_FIRST: first_reg  = val[cte_pkg::FIRST_W-1:0];
			cte_pkg::REG_SPC:   length_reg = val[cte_pkg::SPC_W-1:0];
			default: ;
		endcase
	endtask

	task automatic test_reset_state();
		send_word(32'h0000_0000);
		send_word(32'hFFFF_FFFF);
		send_word(32'h0000_0000);
		send_word(32'hAAAA_AAAA);
		send_word(32'h5555_5555);
	endtask

	task automatic test_pin_layouts();
		write_reg(cte_pkg::REG_PINS, 20'h0);
		send_word(32'h8000_0001);
		write_reg(cte_pkg::REG_PINS, 20'hFFFF3);
		send_word(32'h0000_0003);
		send_word(32'hDEAD_BEEF);
		write_reg(cte_pkg::REG_PINS, 20'h00008);
		send_word(32'h0F0F_F00F);
		write_reg(cte_pkg::REG_PINS, 20'h0000F);
		send_word(32'h1234_5678);
		write_reg(cte_pkg::REG_PINS, 20'h00005);
		send_word(32'hC3A5_5A3C);
		write_reg(cte_pkg::REG_PINS, 20'h00007);
		send_word(32'h7FFF_FFFE);
	endtask

	task automatic test_capture_bounds();
		write_reg(cte_pkg::REG_PINS, 20'h00001);
		write_reg(cte_pkg::REG_SPC, 20'h00000);
		send_word(32'hFFFF_FFFF);
		send_word(32'h0000_0000);
		write_reg(cte_pkg::REG_SPC, 20'd3);
		send_word(32'h0000_0005);
		send_word(32'hFFFF_FFFA);
		// shorten the capture while it is under way
		write_reg(cte_pkg::REG_PINS, 20'd4);
		write_reg(cte_pkg::REG_SPC, 20'd20);
		send_word(32'h1234_ABCD);
		write_reg(cte_pkg::REG_SPC, 20'd5);
		send_word(32'hF0F0_0F0F);
		send_word(32'h0F0F_F0F0);
	endtask

	task automatic test_mid_capture_pins();
		write_reg(cte_pkg::REG_PINS, 20'd2);
		write_reg(cte_pkg::REG_SPC, 20'd100);
		send_word(32'h9696_6969);
		write_reg(cte_pkg::REG_PINS, 20'd6);
		send_word(32'hFFFF_0000);
		send_word(32'h0000_FFFF);
	endtask

	task automatic test_register_index();
		write_reg(REG_UNUSED, 20'hFFFFF);
		write_reg(cte_pkg::REG_PINS, 20'd8);
		write_reg(cte_pkg::REG_FIRST, 20'hFFFE0);
		send_word(32'hFF00_FF00);
		write_reg(cte_pkg::REG_FIRST, 20'h0001F);
		send_word(32'h00FF_00FF);
	endtask

	task automatic randomize_setup(input bit write_all);
		logic [cte_pkg::CFG_DATA_W-1:0] val;
		if (write_all || $urandom_range(3) != 0) begin
			val = cte_pkg::CFG_DATA_W'($urandom);
			case ($urandom_range(5))
				0: val[cte_pkg::PINCFG_W-1:0] = 4'd1;
				1: val[cte_pkg::PINCFG_W-1:0] = 4'd8;
				2: val[cte_pkg::PINCFG_W-1:0] = $urandom_range(1) ? 4'd0 : 4'd15;
				default: val[cte_pkg::PINCFG_W-1:0] =
					cte_pkg::PINCFG_W'($urandom_range(1, 8));
			endcase
			write_reg(cte_pkg::REG_PINS, val);
		end
		if (write_all || $urandom_range(3) != 0) begin
			val = cte_pkg::CFG_DATA_W'($urandom);
			case ($urandom_range(3))
				0: val[cte_pkg::FIRST_W-1:0] = 5'd0;
				1: val[cte_pkg::FIRST_W-1:0] = 5'd31;
				default: ;
			endcase
			write_reg(cte_pkg::REG_FIRST, val);
		end
		if (write_all || $urandom_range(3) != 0) begin
			case ($urandom_range(9))
				0: val = 20'd0;
				1: val = 20'd1;
				2: val = 20'hFFFFF;
				3: val = cte_pkg::CFG_DATA_W'($urandom_range(41, 5000));
				default: val = cte_pkg::CFG_DATA_W'($urandom_range(2, 40));
			endcase
			write_reg(cte_pkg::REG_SPC, val);
		end
	endtask

	task automatic test_random_traffic();
		int unsigned pick;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			randomize_setup(ph == 0);
			calm = (ph == 3);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				pick = $urandom_range(9);
				if (pick < 2)
					send_word($urandom);
				else if (pick == 2)
					send_word(quiet_word(0));
				else
					send_word(quiet_word($urandom_range(1, 4)));
			end
			calm = 1'b0;
		end
	endtask

	initial begin
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = cte_pkg::REG_PINS;
		cfg_data             = '0;
		cap_bus.valid        = 1'b0;
		cap_bus.capture_word = '0;
		evt_bus.ready        = 1'b0;
		pins_reg             = cte_pkg::RST_PINS;
		first_reg            = cte_pkg::RST_FIRST;
		length_reg           = cte_pkg::RST_SPC;
		pin_level            = '0;
		capture_pos          = '0;
		sample_clock         = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_pin_layouts();
		test_capture_bounds();
		test_mid_capture_pins();
		test_register_index();
		test_random_traffic();

		settle();
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
